/* hdl/isq_pkg.sv */
// Package: item types and widths for the int8 symmetric quantizer.
`timescale 1ns / 1ps
package isq_pkg;

  localparam int WeightBits = 16;
  localparam int QuantBits  = 8;
  localparam int ProdBits   = WeightBits + QuantBits - 1;
  localparam int StepBits   = $clog2(QuantBits);

  localparam logic [QuantBits-1:0] QuantMax = {1'b0, {(QuantBits-1){1'b1}}};

  localparam logic ActMeasure  = 1'b0;
  localparam logic ActQuantize = 1'b1;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StFin  = 3'b100
  } state_e;

  typedef struct packed {
    logic                         action;
    logic                         first;
    logic signed [WeightBits-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic signed [QuantBits-1:0] quant;
    logic [WeightBits-1:0]       peak;
  } out_item_t;

endpackage

/* hdl/int8_symmetric_quantizer_unit.sv */
// Top level: per-tensor absmax int8 quantizer with a single restoring divider.
//
// Input channel in_valid_i / in_ready_o / in_item_i carries measure items
// (action = 0) and quantize items (action = 1). A measure item updates the
// running peak |w| in the cycle it is accepted and returns nothing; first = 1
// restarts the peak. A quantize item returns quant = trunc(w * 127 / peak),
// saturated to -127..127, together with peak, on out_valid_o / out_ready_i /
// out_item_o. A zero peak gives quant = 0.
// Flow: measure items stream at one per cycle while the divider is idle; a
// quantize item runs the divider from acceptance to a valid result:
// one subtract-and-shift step of the divider per quotient bit (8 steps),
// then the StFin state writes the result. in_ready_o is low in StDiv and
// StFin, so no new item is accepted until that result is written.
// The result sits in an output register; the block accepts new items while
// it waits to be taken. If the receiver stalls, a following quantize result
// is held in its final step until the output register frees.
// Reset clears the running peak to 0 and empties the output register.
`timescale 1ns / 1ps
module int8_symmetric_quantizer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  isq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output isq_pkg::out_item_t out_item_o
);

  localparam int WB = isq_pkg::WeightBits;
  localparam int QB = isq_pkg::QuantBits;
  localparam int PB = isq_pkg::ProdBits;
  localparam int SB = isq_pkg::StepBits;

  isq_pkg::state_e     state_q, state_d;
  logic [SB-1:0]       cnt_q, cnt_d;
  logic [WB-1:0]       peak_q, peak_d;
  logic                out_valid_q, out_valid_d;
  logic [PB-1:0]       rem_q, rem_d;
  logic [PB-1:0]       dvs_q, dvs_d;
  logic [QB-1:0]       quo_q, quo_d;
  logic                neg_q, neg_d;
  logic                zero_q, zero_d;
  isq_pkg::out_item_t  out_q, out_d;

  logic          accept;
  logic [WB-1:0] w_raw;
  logic [WB-1:0] mag;
  logic [PB-1:0] prod;
  logic [PB:0]   diff;
  logic          fits;
  logic          out_free;
  logic [QB-1:0] qmag;

  assign in_ready_o  = (state_q == isq_pkg::StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign w_raw = in_item_i.weight;
  assign mag   = w_raw[WB-1] ? (~w_raw + {{(WB-1){1'b0}}, 1'b1}) : w_raw;
  // multiply by 2^(QB-1) - 1
  assign prod  = {mag, {(QB-1){1'b0}}} - {{(QB-1){1'b0}}, mag};

  assign diff = {1'b0, rem_q} - {1'b0, dvs_q};
  assign fits = !diff[PB];

  always_comb begin
    qmag = quo_q[QB-1] ? isq_pkg::QuantMax : quo_q;
    if (zero_q) begin
      qmag = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    peak_d      = peak_q;
    out_valid_d = out_valid_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    zero_d      = zero_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      isq_pkg::StIdle: begin
        if (accept) begin
          if (in_item_i.action == isq_pkg::ActMeasure) begin
            if (in_item_i.first || (mag > peak_q)) begin
              peak_d = mag;
            end
          end else begin
            rem_d   = prod;
            dvs_d   = {peak_q, {(QB-1){1'b0}}};
            neg_d   = w_raw[WB-1];
            zero_d  = (peak_q == '0);
            cnt_d   = SB'(QB - 1);
            state_d = isq_pkg::StDiv;
          end
        end
      end
      isq_pkg::StDiv: begin
        if (fits) begin
          rem_d = diff[PB-1:0];
        end
        quo_d = {quo_q[QB-2:0], fits};
        dvs_d = {1'b0, dvs_q[PB-1:1]};
        cnt_d = cnt_q - {{(SB-1){1'b0}}, 1'b1};
        if (cnt_q == '0) begin
          state_d = isq_pkg::StFin;
        end
      end
      isq_pkg::StFin: begin
        if (out_free) begin
          out_d.quant = neg_q ? (~qmag + {{(QB-1){1'b0}}, 1'b1}) : qmag;
          out_d.peak  = peak_q;
          out_valid_d = 1'b1;
          state_d     = isq_pkg::StIdle;
        end
      end
      default: begin
        state_d = isq_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isq_pkg::StIdle;
      cnt_q       <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    out_q  <= out_d;
  end

endmodule
